// ----- hw/rtl/ctd_pkg.sv -----
// ----------------------------------------------------------------------------
// ctd_pkg: shared types and constants of the capture tachometer
// Field widths, register codes and reset values, and the status struct
// that the interval ring reports to the sequencer, and the request struct that the sequencer sends to it.
// ----------------------------------------------------------------------------
package ctd_pkg;

  // Field widths of the stream items and registers.
  localparam int TIMER_W    = 16;
  localparam int SUM_OUT_W  = 19;
  localparam int RPM_W      = 21;
  localparam int DIFF_W     = 17;
  localparam int CFG_W      = 24;
  localparam int TOTAL_W    = 32;
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USER_W = 2;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Register codes, taken from the word address of the APB port.
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_SCALE     = 1'b1;

  // Register values after reset.
  localparam logic [CFG_W-1:0] THRESHOLD_RESET = 24'd100000;
  localparam logic [CFG_W-1:0] SCALE_RESET     = 24'd1887000;

  // Requests from the sequencer to the interval ring.
  typedef struct packed {
    logic wr_en;
    logic scan_start;
  } ring_ctrl_t;

  // Status of a ring scan.
  typedef struct packed {
    logic done;
    logic all_nonzero;
  } ring_stat_t;

endpackage

// ----- hw/rtl/ctd_ring.sv -----
// ----------------------------------------------------------------------------
// ctd_ring: interval ring with a sequential summing scan
// Holds the last RING_DEPTH intervals in a small memory. A scan reads one
// entry per cycle and adds it into a running sum through one shared adder,
// checking at the same time that every entry is nonzero.
// ----------------------------------------------------------------------------
module ctd_ring #(
  parameter int RING_DEPTH = 8,
  parameter int SUM_W      = 19
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ctd_pkg::ring_ctrl_t     ctrl,
  input  logic [ctd_pkg::TIMER_W-1:0] wr_data,
  output ctd_pkg::ring_stat_t     stat,
  output logic [SUM_W-1:0]        sum
);
  import ctd_pkg::*;

  localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W = $clog2(RING_DEPTH + 1);

  logic [TIMER_W-1:0]    mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] valid;
  logic [IDX_W-1:0]      wr_ptr;
  logic [CNT_W-1:0]      scan_cnt;
  logic                  scanning;
  logic                  rd_live;
  logic                  rd_ok;
  logic [TIMER_W-1:0]    rd_data;
  logic                  all_nz;
  logic                  done;
  logic                  issue;
  logic [TIMER_W-1:0]    entry;

  // A read is issued for every entry index of the scan.
  assign issue = scanning && (scan_cnt != CNT_W'(RING_DEPTH));
  // An entry never written since reset reads as zero.
  assign entry = rd_ok ? rd_data : '0;

  // Ring storage with a registered read port.
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
    if (issue) begin
      rd_data <= mem[scan_cnt[IDX_W-1:0]];
    end
  end

  // Write pointer, valid bits and the scan sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      wr_ptr   <= '0;
      scan_cnt <= '0;
      scanning <= 1'b0;
      rd_live  <= 1'b0;
      rd_ok    <= 1'b0;
      all_nz   <= 1'b0;
      done     <= 1'b0;
    end else begin
      done    <= !ctrl.scan_start && scanning && !issue && !rd_live;
      rd_live <= issue;
      if (ctrl.wr_en) begin
        valid[wr_ptr] <= 1'b1;
        wr_ptr <= (wr_ptr == IDX_W'(RING_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (issue) begin
        rd_ok    <= valid[scan_cnt[IDX_W-1:0]];
        scan_cnt <= scan_cnt + 1'b1;
      end
      if (rd_live) begin
        sum <= sum + SUM_W'(entry);
        if (entry == '0) begin
          all_nz <= 1'b0;
        end
      end
      if (ctrl.scan_start) begin
        scanning <= 1'b1;
        scan_cnt <= '0;
        sum      <= '0;
        all_nz   <= 1'b1;
      end else if (scanning && !issue && !rd_live) begin
        scanning <= 1'b0;
      end
    end
  end

  assign stat.done        = done;
  assign stat.all_nonzero = all_nz;

endmodule

// ----- hw/rtl/ctd_div.sv -----
// ----------------------------------------------------------------------------
// ctd_div: serial restoring divider
// Produces one quotient bit per cycle with one shared subtractor.
// ----------------------------------------------------------------------------
module ctd_div #(
  parameter int DVD_W = 24,
  parameter int DSR_W = 19
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);
  import ctd_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DSR_W-1:0] rem;
  logic [DSR_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DSR_W:0]   rem_sh;
  logic [DSR_W+1:0] diff;

  // Bring down the next dividend bit and try the subtraction.
  assign rem_sh = {rem, quotient[DVD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CNT_W'(1));
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CNT_W'(DVD_W);
        quotient <= dividend;
        dsr      <= divisor;
        rem      <= '0;
      end else if (busy) begin
        if (!diff[DSR_W+1]) begin
          rem      <= diff[DSR_W-1:0];
          quotient <= {quotient[DVD_W-2:0], 1'b1};
        end else begin
          rem      <= rem_sh[DSR_W-1:0];
          quotient <= {quotient[DVD_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/capture_tachometer_direction.sv -----
// ----------------------------------------------------------------------------
// capture_tachometer_direction: capture tachometer with direction sense
// One input request is one timer interrupt; one result follows for each.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one interrupt per request: the A and B capture
// values in s_tdata and the A, B and overflow flags in s_tuser. The master
// stream returns exactly one result per request with the interval sum, the
// rpm, the direction difference and the forward flag in m_tdata, and the
// sum and direction valid flags in m_tuser.
// An interrupt that forms no A interval passes from acceptance through the
// A step to the result register, and one that adds an interval passes the
// threshold check as well. One that starts a ring scan waits for the scan,
// and a reported sum also waits for the serial division. At the earliest,
// the next request is taken in the cycle after the result is registered.
// The ring scan (one entry per cycle) and the divider (one quotient bit per
// cycle) are serial steps. One request is worked on at a time; s_tready is
// high only while the sequencer is idle.
// A finished result waits in the output register while the next request is
// taken; when the receiver stalls, the sequencer holds a new result until
// that register is free. Reset empties the ring and all holds and loads the
// register defaults; it needs no clearing pass. The user must write the APB
// registers only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module capture_tachometer_direction #(
  parameter int RING_DEPTH = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // APB configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ctd_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [ctd_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [ctd_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready,
  // Input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // s_tdata: chan_a_capture [15:0], chan_b_capture [31:16]
  input  logic [ctd_pkg::IN_DATA_W-1:0]       s_tdata,
  // s_tuser: chan_a_event [0], chan_b_event [1], overflow_event [2]
  input  logic [ctd_pkg::IN_USER_W-1:0]       s_tuser,
  // Output stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // m_tdata: interval_sum [18:0], rpm [39:19], capture_difference [56:40],
  //          forward [57], zero [63:58]
  output logic [ctd_pkg::OUT_DATA_W-1:0]      m_tdata,
  // m_tuser: sum_valid [0], direction_valid [1]
  output logic [ctd_pkg::OUT_USER_W-1:0]      m_tuser
);
  import ctd_pkg::*;

  localparam int SUM_W = TIMER_W + ((RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1);
  localparam int PAD_W = OUT_DATA_W - (SUM_OUT_W + RPM_W + DIFF_W + 1);

  typedef enum logic [2:0] {
    IDLE,
    A_STEP,
    CHECK,
    SCAN,
    DIVIDE,
    OUTPUT
  } state_t;

  state_t state;

  // Configuration registers
  logic [CFG_W-1:0] message_threshold;
  logic [CFG_W-1:0] rpm_scale;

  // Tachometer and direction state
  logic [TIMER_W-1:0] last_capture;
  logic               have_last;
  logic [TOTAL_W-1:0] running_total;
  logic [TIMER_W-1:0] held_a;
  logic [TIMER_W-1:0] held_b;
  logic               a_is_held;
  logic               b_is_held;
  logic               forward_flag;

  // Latched request and result fields
  logic               a_ev;
  logic [TIMER_W-1:0] a_cap;
  logic               res_sum_valid;
  logic [SUM_OUT_W-1:0] res_sum;
  logic [RPM_W-1:0]   res_rpm;
  logic               res_dir_valid;
  logic [DIFF_W-1:0]  res_diff;

  // Unit connections
  ring_ctrl_t         ring_ctrl;
  ring_stat_t         ring_stat;
  logic [SUM_W-1:0]   ring_sum;
  logic [TIMER_W-1:0] interval;
  logic               div_start;
  logic               div_done;
  logic [CFG_W-1:0]   quotient;

  // Datapath helpers
  logic                 in_accept;
  logic                 in_a_ev;
  logic                 in_b_ev;
  logic                 in_ov_ev;
  logic [TIMER_W-1:0]   in_a_cap;
  logic [TIMER_W-1:0]   in_b_cap;
  logic [TIMER_W-1:0]   hold_a_next;
  logic [TIMER_W-1:0]   hold_b_next;
  logic                 a_held_next;
  logic                 b_held_next;
  logic                 dir_fire;
  logic [TOTAL_W:0]     total_add;
  logic [TOTAL_W-1:0]   total_sat;
  logic                 over_threshold;
  logic [SUM_W+SUM_OUT_W-1:0] sum_wide;
  logic                 cfg_write;

  // Request unpacking
  assign in_accept = s_tvalid && s_tready;
  assign in_a_cap  = s_tdata[TIMER_W-1:0];
  assign in_b_cap  = s_tdata[2*TIMER_W-1:TIMER_W];
  assign in_a_ev   = s_tuser[0];
  assign in_b_ev   = s_tuser[1];
  assign in_ov_ev  = s_tuser[2];
  assign s_tready  = (state == IDLE);

  // Direction: the first capture of each channel is held, then overflow
  // with both held reports their difference.
  assign a_held_next = a_is_held || in_a_ev;
  assign b_held_next = b_is_held || in_b_ev;
  assign hold_a_next = (in_a_ev && !a_is_held) ? in_a_cap : held_a;
  assign hold_b_next = (in_b_ev && !b_is_held) ? in_b_cap : held_b;
  assign dir_fire    = in_ov_ev && a_held_next && b_held_next;

  // Interval since the last A capture wraps with the timer.
  assign interval  = a_cap - last_capture;
  assign total_add = {1'b0, running_total} + (TOTAL_W + 1)'(interval);
  assign total_sat = total_add[TOTAL_W] ? '1 : total_add[TOTAL_W-1:0];
  assign over_threshold = running_total > TOTAL_W'(message_threshold);
  assign sum_wide  = {{SUM_OUT_W{1'b0}}, ring_sum};

  // Unit requests from the sequencer
  always_comb begin
    ring_ctrl.wr_en      = (state == A_STEP) && a_ev && have_last;
    ring_ctrl.scan_start = (state == CHECK) && over_threshold;
    div_start            = (state == SCAN) && ring_stat.done && ring_stat.all_nonzero;
  end

  ctd_ring #(
    .RING_DEPTH (RING_DEPTH),
    .SUM_W      (SUM_W)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ring_ctrl),
    .wr_data (interval),
    .stat    (ring_stat),
    .sum     (ring_sum)
  );

  ctd_div #(
    .DVD_W (CFG_W),
    .DSR_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rpm_scale),
    .divisor  (ring_sum),
    .done     (div_done),
    .quotient (quotient)
  );

  // Configuration registers and read-back
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      message_threshold <= THRESHOLD_RESET;
      rpm_scale         <= SCALE_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_THRESHOLD: message_threshold <= pwdata[CFG_W-1:0];
        REG_SCALE:     rpm_scale         <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_THRESHOLD: prdata = APB_DATA_W'(message_threshold);
      REG_SCALE:     prdata = APB_DATA_W'(rpm_scale);
      default:       prdata = '0;
    endcase
  end

  // Sequencer with tachometer state and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      have_last     <= 1'b0;
      last_capture  <= '0;
      running_total <= '0;
      a_is_held     <= 1'b0;
      b_is_held     <= 1'b0;
      held_a        <= '0;
      held_b        <= '0;
      forward_flag  <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != OUTPUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_accept) begin
            a_ev          <= in_a_ev;
            a_cap         <= in_a_cap;
            res_sum_valid <= 1'b0;
            res_sum       <= '0;
            res_rpm       <= '0;
            if (dir_fire) begin
              res_dir_valid <= 1'b1;
              res_diff      <= {1'b0, hold_a_next} - {1'b0, hold_b_next};
              forward_flag  <= hold_a_next > hold_b_next;
              held_a        <= '0;
              held_b        <= '0;
              a_is_held     <= 1'b0;
              b_is_held     <= 1'b0;
            end else begin
              res_dir_valid <= 1'b0;
              res_diff      <= '0;
              held_a        <= hold_a_next;
              held_b        <= hold_b_next;
              a_is_held     <= a_held_next;
              b_is_held     <= b_held_next;
            end
            state <= A_STEP;
          end
        end
        A_STEP: begin
          if (!a_ev) begin
            state <= OUTPUT;
          end else if (!have_last) begin
            last_capture <= a_cap;
            have_last    <= 1'b1;
            state        <= OUTPUT;
          end else begin
            last_capture  <= a_cap;
            running_total <= total_sat;
            state         <= CHECK;
          end
        end
        CHECK: begin
          state <= over_threshold ? SCAN : OUTPUT;
        end
        SCAN: begin
          if (ring_stat.done) begin
            if (ring_stat.all_nonzero) begin
              res_sum_valid <= 1'b1;
              res_sum       <= sum_wide[SUM_OUT_W-1:0];
              running_total <= '0;
              state         <= DIVIDE;
            end else begin
              state <= OUTPUT;
            end
          end
        end
        DIVIDE: begin
          if (div_done) begin
            res_rpm <= quotient[RPM_W-1:0];
            state   <= OUTPUT;
          end
        end
        OUTPUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{PAD_W{1'b0}}, forward_flag, res_diff, res_rpm, res_sum};
            m_tuser  <= {res_dir_valid, res_sum_valid};
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
